### hw/rtl/com_pkg.sv
// Shared types, constants and mode tables for the chain oiler mode controller.
package com_pkg;

    localparam int PULSES_PER_RUN_DEF = 10;
    localparam int DIST_FRAC_BITS_DEF = 4;
    localparam int QUEUE_DEPTH_DEF    = 2;

    localparam int ACC_W  = 24;
    localparam int INC_W  = 28;
    localparam int CFG_W  = 16;
    localparam int CIDX_W = 3;

    localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

    localparam logic [2:0] OP_SPEED  = 3'd0;
    localparam logic [2:0] OP_DONE   = 3'd1;
    localparam logic [2:0] OP_CLICK  = 3'd2;
    localparam logic [2:0] OP_DOUBLE = 3'd3;
    localparam logic [2:0] OP_HOLD   = 3'd4;

    localparam logic [2:0] MODE_OFF        = 3'd0;
    localparam logic [2:0] MODE_OILING     = 3'd1;
    localparam logic [2:0] MODE_RAIN       = 3'd2;
    localparam logic [2:0] MODE_PUMP_ON    = 3'd3;
    localparam logic [2:0] MODE_PUMP_OFF   = 3'd4;
    localparam logic [2:0] MODE_FORCED_ON  = 3'd5;
    localparam logic [2:0] MODE_FORCED_OFF = 3'd6;
    localparam logic [2:0] MODE_UNUSED     = 3'd7;

    localparam logic [CIDX_W-1:0] REG_MIN_SPEED   = 3'd0;
    localparam logic [CIDX_W-1:0] REG_MAX_SPEED   = 3'd1;
    localparam logic [CIDX_W-1:0] REG_TOWN_LIMIT  = 3'd2;
    localparam logic [CIDX_W-1:0] REG_ROAD_ONE    = 3'd3;
    localparam logic [CIDX_W-1:0] REG_ROAD_TWO    = 3'd4;
    localparam logic [CIDX_W-1:0] REG_TOWN_ONE    = 3'd5;
    localparam logic [CIDX_W-1:0] REG_TOWN_TWO    = 3'd6;
    localparam logic [CIDX_W-1:0] REG_RAIN_FACTOR = 3'd7;

    typedef enum logic [5:0] {
        EV_SPEED  = 6'b000001,
        EV_DONE   = 6'b000010,
        EV_CLICK  = 6'b000100,
        EV_DOUBLE = 6'b001000,
        EV_HOLD   = 6'b010000,
        EV_NONE   = 6'b100000
    } event_t;

    typedef struct packed {
        logic [8:0]  min_speed;
        logic [8:0]  max_speed;
        logic [8:0]  town_speed_limit;
        logic [15:0] road_interval_one;
        logic [15:0] road_interval_two;
        logic [15:0] town_interval_one;
        logic [15:0] town_interval_two;
        logic [7:0]  rain_factor;
    } cfg_t;

    typedef struct packed {
        event_t           kind;
        logic [8:0]       speed;
        logic [INC_W-1:0] inc_plain;
        logic [INC_W-1:0] inc_rain;
    } entry_t;

    typedef struct packed {
        logic       pulse_pump_one;
        logic       pulse_pump_two;
        logic       pumping_active;
        logic [2:0] current_mode;
        logic       mode_changed;
    } result_t;

    function automatic logic [2:0] next_click(input logic [2:0] m);
        logic [2:0] r;
        case (m)
            MODE_OFF:        r = MODE_OILING;
            MODE_OILING:     r = MODE_RAIN;
            MODE_RAIN:       r = MODE_OILING;
            MODE_PUMP_ON:    r = MODE_PUMP_OFF;
            MODE_PUMP_OFF:   r = MODE_PUMP_ON;
            MODE_FORCED_ON:  r = MODE_FORCED_OFF;
            MODE_FORCED_OFF: r = MODE_FORCED_ON;
            default:         r = MODE_OILING;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] next_double(input logic [2:0] m);
        logic [2:0] r;
        case (m)
            MODE_PUMP_ON:  r = MODE_OILING;
            MODE_PUMP_OFF: r = MODE_OILING;
            default:       r = MODE_PUMP_OFF;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] next_hold(input logic [2:0] m);
        logic [2:0] r;
        case (m)
            MODE_OFF:        r = MODE_OILING;
            MODE_FORCED_ON:  r = MODE_OFF;
            MODE_FORCED_OFF: r = MODE_OFF;
            MODE_UNUSED:     r = MODE_OILING;
            default:         r = MODE_FORCED_OFF;
        endcase
        return r;
    endfunction

endpackage

### hw/rtl/com_queue.sv
// Small register-based FIFO used between the stages and for the result queue.
module com_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] slots [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= wdata;
        end
    end

endmodule

### hw/rtl/com_front.sv
// Front stage: decodes the event request and precomputes distance increments.
module com_front #(
    parameter int DIST_FRAC_BITS = com_pkg::DIST_FRAC_BITS_DEF,
    parameter int QUEUE_DEPTH    = com_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  com_pkg::cfg_t   cfg,
    input  logic            push,
    input  logic [2:0]      opcode,
    input  logic [8:0]      speed_value,
    input  logic [15:0]     distance_delta,
    output logic            full,
    input  logic            take,
    output com_pkg::entry_t entry,
    output logic            entry_valid
);

    import com_pkg::*;

    localparam int LSH = (DIST_FRAC_BITS >= 4) ? DIST_FRAC_BITS - 4 : 0;
    localparam int RSH = (DIST_FRAC_BITS >= 4) ? 0 : 4 - DIST_FRAC_BITS;

    entry_t      req;
    logic [23:0] prod;
    logic        q_empty;

    always_comb
    begin
        case (opcode)
            OP_SPEED:  req.kind = EV_SPEED;
            OP_DONE:   req.kind = EV_DONE;
            OP_CLICK:  req.kind = EV_CLICK;
            OP_DOUBLE: req.kind = EV_DOUBLE;
            OP_HOLD:   req.kind = EV_HOLD;
            default:   req.kind = EV_NONE;
        endcase
        prod          = 24'(distance_delta) * 24'(cfg.rain_factor);
        req.speed     = speed_value;
        req.inc_plain = INC_W'(distance_delta) << DIST_FRAC_BITS;
        req.inc_rain  = (INC_W'(prod) >> RSH) << LSH;
    end

    com_queue #(
        .WIDTH($bits(entry_t)),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (req),
        .full  (full),
        .pop   (take),
        .rdata (entry),
        .empty (q_empty)
    );

    assign entry_valid = !q_empty;

endmodule

### hw/rtl/com_back.sv
// Back stage: mode update, distance accumulators, pump decisions, result queue.
module com_back #(
    parameter int PULSES_PER_RUN = com_pkg::PULSES_PER_RUN_DEF,
    parameter int DIST_FRAC_BITS = com_pkg::DIST_FRAC_BITS_DEF,
    parameter int QUEUE_DEPTH    = com_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  com_pkg::cfg_t   cfg,
    input  com_pkg::entry_t entry,
    input  logic            entry_valid,
    output logic            take,
    input  logic            pop,
    output logic            empty,
    output com_pkg::result_t result
);

    import com_pkg::*;

    localparam int CNT_W = $clog2(PULSES_PER_RUN + 1);
    localparam logic [CNT_W-1:0] CNT_END = CNT_W'(PULSES_PER_RUN);

    logic [2:0]       mode_reg, mode_next;
    logic [8:0]       speed_reg, speed_next;
    logic [ACC_W-1:0] dist_one_reg, dist_one_next;
    logic [ACC_W-1:0] dist_two_reg, dist_two_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             run_reg, run_next;

    logic             out_full;
    logic [INC_W-1:0] inc;
    logic [INC_W:0]   sum_one, sum_two;
    logic [ACC_W-1:0] iv_one, iv_two;
    logic             road, in_band, p1, p2, changed;
    result_t          res;

    assign take = entry_valid && !out_full;

    always_comb
    begin
        mode_next     = mode_reg;
        speed_next    = speed_reg;
        dist_one_next = dist_one_reg;
        dist_two_next = dist_two_reg;
        cnt_next      = cnt_reg;
        run_next      = run_reg;
        changed       = 1'b0;
        p1            = 1'b0;
        p2            = 1'b0;

        inc     = (mode_reg == MODE_OILING) ? entry.inc_plain : entry.inc_rain;
        sum_one = (INC_W + 1)'(dist_one_reg) + (INC_W + 1)'(inc);
        sum_two = (INC_W + 1)'(dist_two_reg) + (INC_W + 1)'(inc);

        case (entry.kind)
            EV_SPEED:
            begin
                speed_next = entry.speed;
                if (mode_reg == MODE_OILING || mode_reg == MODE_RAIN)
                begin
                    dist_one_next = (sum_one > (INC_W + 1)'(ACC_MAX)) ? ACC_MAX
                                                                     : ACC_W'(sum_one);
                    dist_two_next = (sum_two > (INC_W + 1)'(ACC_MAX)) ? ACC_MAX
                                                                     : ACC_W'(sum_two);
                end
            end
            EV_DONE:
            begin
                if (mode_reg == MODE_PUMP_ON || mode_reg == MODE_FORCED_ON)
                begin
                    if (cnt_reg >= CNT_END)
                    begin
                        cnt_next  = '0;
                        mode_next = (mode_reg == MODE_PUMP_ON) ? MODE_PUMP_OFF
                                                               : MODE_FORCED_OFF;
                        changed   = 1'b1;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            EV_CLICK:
            begin
                run_next  = 1'b0;
                mode_next = next_click(mode_reg);
                changed   = 1'b1;
            end
            EV_DOUBLE:
            begin
                run_next  = 1'b0;
                mode_next = next_double(mode_reg);
                changed   = 1'b1;
            end
            EV_HOLD:
            begin
                run_next  = 1'b0;
                mode_next = next_hold(mode_reg);
                changed   = 1'b1;
            end
            default:
            begin
            end
        endcase

        road    = speed_next > cfg.town_speed_limit;
        in_band = (speed_next >= cfg.min_speed) && (speed_next <= cfg.max_speed);
        iv_one  = ACC_W'(road ? cfg.road_interval_one : cfg.town_interval_one)
                  << DIST_FRAC_BITS;
        iv_two  = ACC_W'(road ? cfg.road_interval_two : cfg.town_interval_two)
                  << DIST_FRAC_BITS;

        case (mode_next)
            MODE_OILING, MODE_RAIN:
            begin
                if (in_band)
                begin
                    if (dist_one_next > iv_one)
                    begin
                        dist_one_next = '0;
                        p1            = 1'b1;
                    end
                    if (dist_two_next > iv_two)
                    begin
                        dist_two_next = '0;
                        p2            = 1'b1;
                    end
                end
            end
            MODE_PUMP_ON:
            begin
                run_next = (speed_next > cfg.min_speed) && (speed_next < cfg.max_speed);
            end
            MODE_FORCED_ON:
            begin
                run_next = 1'b1;
            end
            default:
            begin
                run_next = 1'b0;
            end
        endcase

        res.pulse_pump_one = p1;
        res.pulse_pump_two = p2;
        res.pumping_active = run_next;
        res.current_mode   = mode_next;
        res.mode_changed   = changed;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_OFF;
            speed_reg    <= '0;
            dist_one_reg <= '0;
            dist_two_reg <= '0;
            cnt_reg      <= '0;
            run_reg      <= 1'b0;
        end
        else if (take)
        begin
            mode_reg     <= mode_next;
            speed_reg    <= speed_next;
            dist_one_reg <= dist_one_next;
            dist_two_reg <= dist_two_next;
            cnt_reg      <= cnt_next;
            run_reg      <= run_next;
        end
    end

    com_queue #(
        .WIDTH($bits(result_t)),
        .DEPTH(QUEUE_DEPTH)
    ) u_out_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (take),
        .wdata (res),
        .full  (out_full),
        .pop   (pop),
        .rdata (result),
        .empty (empty)
    );

endmodule

### hw/rtl/chain_oiler_mode_controller.sv
// Top level of the chain oiler mode controller: config registers and stage wiring.
//
// Input side is a queue: present opcode, speed_value and distance_delta with
// push; the request is taken on a clock edge where push is high and full is low.
// Result side is a queue: while empty is low the oldest result sits on the
// result ports; it is taken on an edge where pop is high. Every event request
// yields exactly one result.
// A taken request waits in the event queue until the back stage takes it and
// writes its result into the result queue; it then shows on the result ports.
// Throughput: one request per cycle while the result queue has room; the
// mode/accumulator update in the back stage is combinational and registered when
// a request is taken, the rain multiply is done in the front stage.
// When pop stays low the result queue fills, the back stage halts, then the
// event queue fills and full rises; nothing is dropped.
// Config: cfg_write with cfg_index/cfg_data writes one register at the edge;
// write only while both queues are empty.
// Reset (rst_n low, asynchronous) empties both queues, sets mode off, clears
// speed, accumulators, pulse count and the pump flag, and loads register defaults.
module chain_oiler_mode_controller #(
    parameter int PULSES_PER_RUN = com_pkg::PULSES_PER_RUN_DEF,
    parameter int DIST_FRAC_BITS = com_pkg::DIST_FRAC_BITS_DEF,
    parameter int QUEUE_DEPTH    = com_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write,
    input  logic [com_pkg::CIDX_W-1:0] cfg_index,
    input  logic [com_pkg::CFG_W-1:0]  cfg_data,
    input  logic                       push,
    output logic                       full,
    input  logic [2:0]                 opcode,
    input  logic [8:0]                 speed_value,
    input  logic [15:0]                distance_delta,
    output logic                       empty,
    input  logic                       pop,
    output logic                       pulse_pump_one,
    output logic                       pulse_pump_two,
    output logic                       pumping_active,
    output logic [2:0]                 current_mode,
    output logic                       mode_changed
);

    import com_pkg::*;

    cfg_t    cfg_reg;
    entry_t  entry;
    logic    entry_valid;
    logic    take;
    result_t result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_speed         <= 9'd5;
            cfg_reg.max_speed         <= 9'd200;
            cfg_reg.town_speed_limit  <= 9'd60;
            cfg_reg.road_interval_one <= 16'd1000;
            cfg_reg.road_interval_two <= 16'd1000;
            cfg_reg.town_interval_one <= 16'd500;
            cfg_reg.town_interval_two <= 16'd500;
            cfg_reg.rain_factor       <= 8'd16;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_MIN_SPEED:   cfg_reg.min_speed         <= cfg_data[8:0];
                REG_MAX_SPEED:   cfg_reg.max_speed         <= cfg_data[8:0];
                REG_TOWN_LIMIT:  cfg_reg.town_speed_limit  <= cfg_data[8:0];
                REG_ROAD_ONE:    cfg_reg.road_interval_one <= cfg_data;
                REG_ROAD_TWO:    cfg_reg.road_interval_two <= cfg_data;
                REG_TOWN_ONE:    cfg_reg.town_interval_one <= cfg_data;
                REG_TOWN_TWO:    cfg_reg.town_interval_two <= cfg_data;
                REG_RAIN_FACTOR: cfg_reg.rain_factor       <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    com_front #(
        .DIST_FRAC_BITS (DIST_FRAC_BITS),
        .QUEUE_DEPTH    (QUEUE_DEPTH)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .push           (push),
        .opcode         (opcode),
        .speed_value    (speed_value),
        .distance_delta (distance_delta),
        .full           (full),
        .take           (take),
        .entry          (entry),
        .entry_valid    (entry_valid)
    );

    com_back #(
        .PULSES_PER_RUN (PULSES_PER_RUN),
        .DIST_FRAC_BITS (DIST_FRAC_BITS),
        .QUEUE_DEPTH    (QUEUE_DEPTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .entry       (entry),
        .entry_valid (entry_valid),
        .take        (take),
        .pop         (pop),
        .empty       (empty),
        .result      (result)
    );

    assign pulse_pump_one = result.pulse_pump_one;
    assign pulse_pump_two = result.pulse_pump_two;
    assign pumping_active = result.pumping_active;
    assign current_mode   = result.current_mode;
    assign mode_changed   = result.mode_changed;

endmodule

### dv/chain_oiler_mode_controller_checker.sv
// Checker for the chain oiler mode controller: predicts each result and compares it.
module chain_oiler_mode_controller_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write,
    input  logic [com_pkg::CIDX_W-1:0] cfg_index,
    input  logic [com_pkg::CFG_W-1:0]  cfg_data,
    input  logic                       push,
    input  logic                       full,
    input  logic [2:0]                 opcode,
    input  logic [8:0]                 speed_value,
    input  logic [15:0]                distance_delta,
    input  logic                       empty,
    input  logic                       pop,
    input  logic                       pulse_pump_one,
    input  logic                       pulse_pump_two,
    input  logic                       pumping_active,
    input  logic [2:0]                 current_mode,
    input  logic                       mode_changed,
    output int                         mismatch_count,
    output int                         outstanding,
    output int                         checked_count
);
    import com_pkg::*;

    localparam int RUN_PULSES = PULSES_PER_RUN_DEF;
    localparam int FRAC_BITS  = DIST_FRAC_BITS_DEF;

    cfg_t        settings;
    logic [2:0]  mode;
    logic [8:0]  speed_seen;
    logic [23:0] dist_one;
    logic [23:0] dist_two;
    logic [7:0]  done_count;
    logic        pump_on;
    result_t     predicted_q[$];
    int          errors = 0;
    int          checked = 0;

    function automatic logic [23:0] saturate_add(input logic [23:0] acc, input logic [63:0] inc);
        logic [63:0] sum;
        sum = 64'(acc) + inc;
        return (sum > 64'(ACC_MAX)) ? ACC_MAX : sum[23:0];
    endfunction

    // one event through the controller, then the per-step pump update
    function automatic result_t advance_controller(input logic [2:0] op, input logic [8:0] spd,
                                                   input logic [15:0] dlt);
        logic [2:0]  m;
        logic [63:0] inc;
        logic [63:0] lim_one;
        logic [63:0] lim_two;
        logic        road;
        result_t     r;
        m = mode;
        r = '0;
        case (op)
            OP_SPEED:
            begin
                speed_seen = spd;
                if (m == MODE_OILING || m == MODE_RAIN)
                begin
                    if (m == MODE_OILING)
                        inc = 64'(dlt) << FRAC_BITS;
                    else if (FRAC_BITS >= 4)
                        inc = (64'(dlt) * 64'(settings.rain_factor)) << (FRAC_BITS - 4);
                    else
                        inc = (64'(dlt) * 64'(settings.rain_factor)) >> (4 - FRAC_BITS);
                    dist_one = saturate_add(dist_one, inc);
                    dist_two = saturate_add(dist_two, inc);
                end
            end
            OP_DONE:
            begin
                if (m == MODE_PUMP_ON || m == MODE_FORCED_ON)
                begin
                    if (done_count >= RUN_PULSES)
                    begin
                        done_count = '0;
                        m = (m == MODE_PUMP_ON) ? MODE_PUMP_OFF : MODE_FORCED_OFF;
                        r.mode_changed = 1'b1;
                    end
                    else
                    begin
                        done_count = done_count + 8'd1;
                    end
                end
            end
            OP_CLICK, OP_DOUBLE, OP_HOLD:
            begin
                pump_on = 1'b0;
                r.mode_changed = 1'b1;
                if (op == OP_CLICK)
                begin
                    case (m)
                        MODE_OFF:        m = MODE_OILING;
                        MODE_OILING:     m = MODE_RAIN;
                        MODE_RAIN:       m = MODE_OILING;
                        MODE_PUMP_ON:    m = MODE_PUMP_OFF;
                        MODE_PUMP_OFF:   m = MODE_PUMP_ON;
                        MODE_FORCED_ON:  m = MODE_FORCED_OFF;
                        MODE_FORCED_OFF: m = MODE_FORCED_ON;
                        default:         m = MODE_OILING;
                    endcase
                end
                else if (op == OP_DOUBLE)
                begin
                    m = (m == MODE_PUMP_ON || m == MODE_PUMP_OFF) ? MODE_OILING : MODE_PUMP_OFF;
                end
                else
                begin
                    case (m)
                        MODE_OFF, MODE_UNUSED:           m = MODE_OILING;
                        MODE_FORCED_ON, MODE_FORCED_OFF: m = MODE_OFF;
                        default:                         m = MODE_FORCED_OFF;
                    endcase
                end
            end
            default:
            begin
            end
        endcase
        mode = m;

        if (m == MODE_OILING || m == MODE_RAIN)
        begin
            if (speed_seen >= settings.min_speed && speed_seen <= settings.max_speed)
            begin
                road = speed_seen > settings.town_speed_limit;
                lim_one = 64'(road ? settings.road_interval_one : settings.town_interval_one)
                          << FRAC_BITS;
                lim_two = 64'(road ? settings.road_interval_two : settings.town_interval_two)
                          << FRAC_BITS;
                if (64'(dist_one) > lim_one)
                begin
                    dist_one = '0;
                    r.pulse_pump_one = 1'b1;
                end
                if (64'(dist_two) > lim_two)
                begin
                    dist_two = '0;
                    r.pulse_pump_two = 1'b1;
                end
            end
        end
        else if (m == MODE_PUMP_ON)
        begin
            pump_on = (speed_seen > settings.min_speed && speed_seen < settings.max_speed);
        end
        else if (m == MODE_FORCED_ON)
        begin
            pump_on = 1'b1;
        end
        else
        begin
            pump_on = 1'b0;
        end
        r.pumping_active = pump_on;
        r.current_mode = mode;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        result_t want;
        result_t got;
        if (!rst_n)
        begin
            settings.min_speed         = 9'd5;
            settings.max_speed         = 9'd200;
            settings.town_speed_limit  = 9'd60;
            settings.road_interval_one = 16'd1000;
            settings.road_interval_two = 16'd1000;
            settings.town_interval_one = 16'd500;
            settings.town_interval_two = 16'd500;
            settings.rain_factor       = 8'd16;
            mode       = MODE_OFF;
            speed_seen = '0;
            dist_one   = '0;
            dist_two   = '0;
            done_count = '0;
            pump_on    = 1'b0;
            predicted_q.delete();
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_MIN_SPEED:   settings.min_speed         = cfg_data[8:0];
                    REG_MAX_SPEED:   settings.max_speed         = cfg_data[8:0];
                    REG_TOWN_LIMIT:  settings.town_speed_limit  = cfg_data[8:0];
                    REG_ROAD_ONE:    settings.road_interval_one = cfg_data;
                    REG_ROAD_TWO:    settings.road_interval_two = cfg_data;
                    REG_TOWN_ONE:    settings.town_interval_one = cfg_data;
                    REG_TOWN_TWO:    settings.town_interval_two = cfg_data;
                    REG_RAIN_FACTOR: settings.rain_factor       = cfg_data[7:0];
                    default:
                    begin
                    end
                endcase
            end

            // compare before predicting: a request taken now cannot be answered now
            if (pop && !empty)
            begin
                got.pulse_pump_one = pulse_pump_one;
                got.pulse_pump_two = pulse_pump_two;
                got.pumping_active = pumping_active;
                got.current_mode   = current_mode;
                got.mode_changed   = mode_changed;
                if (predicted_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: result with no request pending: p1=%0b p2=%0b run=%0b mode=%0d changed=%0b",
                                 $time, got.pulse_pump_one, got.pulse_pump_two,
                                 got.pumping_active, got.current_mode, got.mode_changed);
                end
                else
                begin
                    want = predicted_q.pop_front();
                    checked++;
                    if (got != want)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("%0t: mismatch, expected p1=%0b p2=%0b run=%0b mode=%0d changed=%0b, got p1=%0b p2=%0b run=%0b mode=%0d changed=%0b",
                                     $time, want.pulse_pump_one, want.pulse_pump_two,
                                     want.pumping_active, want.current_mode, want.mode_changed,
                                     got.pulse_pump_one, got.pulse_pump_two,
                                     got.pumping_active, got.current_mode, got.mode_changed);
                    end
                end
            end

            if (push && !full)
                predicted_q.push_back(advance_controller(opcode, speed_value, distance_delta));
        end
        mismatch_count <= errors;
        outstanding    <= predicted_q.size();
        checked_count  <= checked;
    end

endmodule

### dv/tb_chain_oiler_mode_controller.sv
// Testbench top for the chain oiler mode controller: stimulus, register settings and verdict.
module tb_chain_oiler_mode_controller;
    import com_pkg::*;

    localparam int PHASE_COUNT        = 6;
    localparam int REQUESTS_PER_PHASE = 175;

    localparam logic [2:0] OP_RESERVED_FIRST = 3'd5;
    localparam logic [2:0] OP_RESERVED_LAST  = 3'd7;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_write = 1'b0;
    logic [CIDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]  cfg_data = '0;
    logic              push = 1'b0;
    logic [2:0]        opcode = OP_SPEED;
    logic [8:0]        speed_value = '0;
    logic [15:0]       distance_delta = '0;
    logic              pop = 1'b0;
    logic              full;
    logic              empty;
    logic              pulse_pump_one;
    logic              pulse_pump_two;
    logic              pumping_active;
    logic [2:0]        current_mode;
    logic              mode_changed;
    int                mismatch_count;
    int                outstanding;
    int                checked_count;

    int send_gap_pct = 9;
    int recv_stall_pct = 66;
    int requests_sent = 0;

    chain_oiler_mode_controller u_top (.*);

    chain_oiler_mode_controller_checker u_checker (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
        pop <= ($urandom_range(99) >= recv_stall_pct);

    initial
    begin
        #4_000_000;
        $display("[chain_oiler_mode_controller] ERROR");
        $finish;
    end

    function automatic logic [8:0] pick_speed();
        int r;
        r = $urandom_range(9);
        if (r == 0)
            return 9'd0;
        else if (r == 1)
            return 9'd511;
        else if (r < 5)
            return 9'($urandom_range(511));
        return 9'($urandom_range(250));
    endfunction

    function automatic logic [15:0] pick_distance();
        int r;
        r = $urandom_range(9);
        if (r == 0)
            return 16'd0;
        else if (r == 1)
            return 16'hFFFF;
        else if (r < 4)
            return 16'($urandom_range(65535));
        return 16'($urandom_range(400));
    endfunction

    task automatic send_request(input logic [2:0] op, input logic [8:0] spd,
                                input logic [15:0] dlt);
        while ($urandom_range(99) < send_gap_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push           <= 1'b1;
        opcode         <= op;
        speed_value    <= spd;
        distance_delta <= dlt;
        do
            @(posedge clk);
        while (full);
        if (op <= OP_HOLD)
            requests_sent++;
    endtask

    task automatic send_noise();
        send_request(3'($urandom_range(7)), 9'($urandom_range(511)),
                     16'($urandom_range(65535)));
    endtask

    task automatic send_button(input logic [2:0] op);
        send_request(op, pick_speed(), pick_distance());
    endtask

    task automatic wait_until_drained();
        push <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_register(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic apply_setting(input int setting);
        cfg_t plan;
        case (setting)
            1:
            begin
                plan.min_speed         = 9'd0;
                plan.max_speed         = 9'd511;
                plan.town_speed_limit  = 9'd0;
                plan.road_interval_one = 16'd0;
                plan.road_interval_two = 16'd0;
                plan.town_interval_one = 16'd0;
                plan.town_interval_two = 16'd0;
                plan.rain_factor       = 8'd0;
            end
            2:
            begin
                plan.min_speed         = 9'd0;
                plan.max_speed         = 9'd511;
                plan.town_speed_limit  = 9'd511;
                plan.road_interval_one = 16'hFFFF;
                plan.road_interval_two = 16'hFFFF;
                plan.town_interval_one = 16'hFFFF;
                plan.town_interval_two = 16'hFFFF;
                plan.rain_factor       = 8'd255;
            end
            3:
            begin
                plan.min_speed         = 9'($urandom_range(511));
                plan.max_speed         = 9'($urandom_range(511));
                plan.town_speed_limit  = 9'($urandom_range(511));
                plan.road_interval_one = 16'($urandom_range(65535));
                plan.road_interval_two = 16'($urandom_range(65535));
                plan.town_interval_one = 16'($urandom_range(65535));
                plan.town_interval_two = 16'($urandom_range(65535));
                plan.rain_factor       = 8'($urandom_range(255));
            end
            4:
            begin
                // single-point speed band at the top of the range
                plan.min_speed         = 9'd511;
                plan.max_speed         = 9'd511;
                plan.town_speed_limit  = 9'd510;
                plan.road_interval_one = 16'($urandom_range(50));
                plan.road_interval_two = 16'($urandom_range(50));
                plan.town_interval_one = 16'($urandom_range(50));
                plan.town_interval_two = 16'($urandom_range(50));
                plan.rain_factor       = 8'd16;
            end
            default:
            begin
                plan.min_speed         = 9'($urandom_range(20));
                plan.max_speed         = 9'($urandom_range(120, 300));
                plan.town_speed_limit  = 9'($urandom_range(30, 100));
                plan.road_interval_one = 16'($urandom_range(20, 1500));
                plan.road_interval_two = 16'($urandom_range(20, 1500));
                plan.town_interval_one = 16'($urandom_range(20, 1500));
                plan.town_interval_two = 16'($urandom_range(20, 1500));
                plan.rain_factor       = 8'($urandom_range(1, 64));
            end
        endcase
        write_register(REG_MIN_SPEED, CFG_W'(plan.min_speed));
        write_register(REG_MAX_SPEED, CFG_W'(plan.max_speed));
        write_register(REG_TOWN_LIMIT, CFG_W'(plan.town_speed_limit));
        write_register(REG_ROAD_ONE, plan.road_interval_one);
        write_register(REG_ROAD_TWO, plan.road_interval_two);
        write_register(REG_TOWN_ONE, plan.town_interval_one);
        write_register(REG_TOWN_TWO, plan.town_interval_two);
        write_register(REG_RAIN_FACTOR, CFG_W'(plan.rain_factor));
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // double then hold lands in forced off from any mode
    task automatic run_random_sequence();
        int kind;
        int n;
        kind = $urandom_range(99);
        if (kind < 40)
        begin
            send_button(OP_DOUBLE);
            send_button(OP_HOLD);
            send_button(OP_HOLD);
            send_button(OP_CLICK);
            if ($urandom_range(1))
                send_button(OP_CLICK);
            n = $urandom_range(4, 20);
            repeat (n)
            begin
                if ($urandom_range(9) == 0)
                    send_noise();
                else
                    send_request(OP_SPEED, pick_speed(), pick_distance());
            end
        end
        else if (kind < 75)
        begin
            send_button(OP_DOUBLE);
            send_button(OP_HOLD);
            if ($urandom_range(1))
            begin
                send_button(OP_CLICK);
            end
            else
            begin
                send_button(OP_HOLD);
                send_button(OP_CLICK);
                send_button(OP_DOUBLE);
                send_button(OP_CLICK);
            end
            send_request(OP_SPEED, pick_speed(), pick_distance());
            n = $urandom_range(6, 14);
            repeat (n)
            begin
                if ($urandom_range(9) == 0)
                    send_request(OP_SPEED, pick_speed(), pick_distance());
                else
                    send_button(OP_DONE);
            end
        end
        else
        begin
            n = $urandom_range(1, 6);
            repeat (n) send_noise();
        end
    endtask

    initial
    begin
        int phase_start;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // register defaults from reset
        send_request(OP_SPEED, 9'd0, 16'd0);
        send_request(OP_RESERVED_FIRST, 9'd511, 16'hFFFF);
        send_request(OP_RESERVED_LAST, 9'd0, 16'd0);
        send_request(OP_DONE, 9'd0, 16'd0);
        send_request(OP_HOLD, 9'd0, 16'd0);
        send_request(OP_SPEED, 9'd511, 16'hFFFF);
        send_request(OP_SPEED, 9'd100, 16'd1);
        send_request(OP_CLICK, 9'd0, 16'd0);
        send_request(OP_SPEED, 9'd5, 16'hFFFF);
        send_request(OP_SPEED, 9'd200, 16'd0);
        send_request(OP_SPEED, 9'd60, 16'd501);
        send_request(OP_DOUBLE, 9'd0, 16'd0);
        send_request(OP_CLICK, 9'd0, 16'd0);
        send_request(OP_SPEED, 9'd5, 16'd0);
        send_request(OP_HOLD, 9'd0, 16'd0);
        send_request(OP_CLICK, 9'd0, 16'd0);
        repeat (PULSES_PER_RUN_DEF + 1) send_request(OP_DONE, 9'd0, 16'd0);

        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            wait_until_drained();
            apply_setting(phase);
            send_gap_pct   = (phase < 2) ? 9 : (phase < 4) ? 66 : 0;
            recv_stall_pct = (phase < 2) ? 66 : (phase < 4) ? 9 : 0;
            phase_start = requests_sent;
            while (requests_sent - phase_start < REQUESTS_PER_PHASE)
                run_random_sequence();
        end

        wait_until_drained();
        repeat (4) @(posedge clk);
        $display("run covered %0d event requests and %0d checked results", requests_sent,
                 checked_count);
        $display("across %0d register settings and three stall patterns", PHASE_COUNT + 1);
        if (mismatch_count == 0)
            $display("[chain_oiler_mode_controller] OK");
        else
            $display("[chain_oiler_mode_controller] ERROR");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/com_pkg.sv
hw/rtl/com_queue.sv
hw/rtl/com_front.sv
hw/rtl/com_back.sv
hw/rtl/chain_oiler_mode_controller.sv
dv/chain_oiler_mode_controller_checker.sv
dv/tb_chain_oiler_mode_controller.sv
